### rtl/lc3s_pkg.sv
package lc3s_pkg;

  // Micro-program addresses.
  typedef logic [4:0] upc_t;

  localparam upc_t U_DISP   = 5'd0;
  localparam upc_t U_LOAD0  = 5'd1;
  localparam upc_t U_LOAD1  = 5'd2;
  localparam upc_t U_LOAD2  = 5'd3;
  localparam upc_t U_RST    = 5'd4;
  localparam upc_t U_EX0    = 5'd5;
  localparam upc_t U_EX1    = 5'd6;
  localparam upc_t U_EX2    = 5'd7;
  localparam upc_t U_EX3    = 5'd8;
  localparam upc_t U_ALU0   = 5'd9;
  localparam upc_t U_ALU1   = 5'd10;
  localparam upc_t U_ALU2   = 5'd11;
  localparam upc_t U_NOT0   = 5'd12;
  localparam upc_t U_NOT1   = 5'd13;
  localparam upc_t U_LD0    = 5'd14;
  localparam upc_t U_LD1    = 5'd15;
  localparam upc_t U_LD2    = 5'd16;
  localparam upc_t U_LD3    = 5'd17;
  localparam upc_t U_ST0    = 5'd18;
  localparam upc_t U_ST1    = 5'd19;
  localparam upc_t U_ST2    = 5'd20;
  localparam upc_t U_ST3    = 5'd21;
  localparam upc_t U_BR     = 5'd22;
  localparam upc_t U_JMP0   = 5'd23;
  localparam upc_t U_JMP1   = 5'd24;
  localparam upc_t U_TRAP   = 5'd25;
  localparam upc_t U_REPORT = 5'd26;

  // Request operation codes.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_EXEC    = 2'd2;

  // Instruction opcodes.
  localparam logic [3:0] OPC_BR   = 4'd0;
  localparam logic [3:0] OPC_ADD  = 4'd1;
  localparam logic [3:0] OPC_LD   = 4'd2;
  localparam logic [3:0] OPC_ST   = 4'd3;
  localparam logic [3:0] OPC_AND  = 4'd5;
  localparam logic [3:0] OPC_NOT  = 4'd9;
  localparam logic [3:0] OPC_JMP  = 4'd12;
  localparam logic [3:0] OPC_TRAP = 4'd15;

  // Condition codes.
  localparam logic [1:0] CC_NEG  = 2'd0;
  localparam logic [1:0] CC_ZERO = 2'd1;
  localparam logic [1:0] CC_POS  = 2'd2;

  localparam logic [7:0] HALT_VECTOR = 8'h25;

  typedef enum logic [2:0] {J_NEXT, J_GOTO, J_WAIT, J_DISP_OP, J_DISP_OPC} jmp_t;
  typedef enum logic [1:0] {MS_PC, MS_OFF, MS_LOAD} msel_t;
  typedef enum logic {WD_LOAD, WD_A} wsel_t;
  typedef enum logic [1:0] {RS_RS1, RS_RS2, RS_RD} rsel_t;
  typedef enum logic [1:0] {RES_ALU, RES_NOT, RES_MEM} res_t;
  typedef enum logic [1:0] {PC_KEEP, PC_BR, PC_JMP} pcop_t;
  typedef enum logic [2:0] {WV_KEEP, WV_CLEAR, WV_RES, WV_A, WV_LOAD} wv_t;

  // One micro-instruction.
  typedef struct packed {
    jmp_t  jmp;
    upc_t  target;
    logic  mod_go;
    msel_t msel;
    logic  mem_rd;
    logic  mem_we;
    wsel_t wsel;
    logic  ir_ld;
    logic  rf_rd;
    rsel_t rsel;
    logic  a_ld;
    logic  wb;
    res_t  rsrc;
    pcop_t pc_op;
    logic  restart;
    logic  trap;
    wv_t   wv;
    logic  out_stb;
  } ctrl_t;

  // Status seen by the sequencer for its jumps.
  typedef struct packed {
    logic       go;
    logic [1:0] op;
    logic       halted;
    logic [3:0] opcode;
    logic       mod_done;
  } cond_t;

  // Control store.
  function automatic ctrl_t ucode(input upc_t a);
    ctrl_t c;
    c = '0;
    unique case (a)
      U_DISP:   begin c.jmp = J_DISP_OP; c.wv = WV_CLEAR; end
      U_LOAD0:  begin c.mod_go = 1'b1; c.msel = MS_LOAD; end
      U_LOAD1:  c.jmp = J_WAIT;
      U_LOAD2:  begin
        c.jmp = J_GOTO; c.target = U_REPORT;
        c.mem_we = 1'b1; c.wsel = WD_LOAD; c.wv = WV_LOAD;
      end
      U_RST:    begin c.jmp = J_GOTO; c.target = U_REPORT; c.restart = 1'b1; end
      U_EX0:    begin c.mod_go = 1'b1; c.msel = MS_PC; end
      U_EX1:    c.jmp = J_WAIT;
      U_EX2:    c.mem_rd = 1'b1;
      U_EX3:    begin c.jmp = J_DISP_OPC; c.ir_ld = 1'b1; end
      U_ALU0:   begin c.rf_rd = 1'b1; c.rsel = RS_RS1; end
      U_ALU1:   begin c.a_ld = 1'b1; c.rf_rd = 1'b1; c.rsel = RS_RS2; end
      U_ALU2:   begin
        c.jmp = J_GOTO; c.target = U_REPORT;
        c.wb = 1'b1; c.rsrc = RES_ALU; c.wv = WV_RES;
      end
      U_NOT0:   begin c.rf_rd = 1'b1; c.rsel = RS_RS1; end
      U_NOT1:   begin
        c.jmp = J_GOTO; c.target = U_REPORT;
        c.wb = 1'b1; c.rsrc = RES_NOT; c.wv = WV_RES;
      end
      U_LD0:    begin c.mod_go = 1'b1; c.msel = MS_OFF; end
      U_LD1:    c.jmp = J_WAIT;
      U_LD2:    c.mem_rd = 1'b1;
      U_LD3:    begin
        c.jmp = J_GOTO; c.target = U_REPORT;
        c.wb = 1'b1; c.rsrc = RES_MEM; c.wv = WV_RES;
      end
      U_ST0:    begin c.rf_rd = 1'b1; c.rsel = RS_RD; end
      U_ST1:    begin c.a_ld = 1'b1; c.mod_go = 1'b1; c.msel = MS_OFF; end
      U_ST2:    c.jmp = J_WAIT;
      U_ST3:    begin
        c.jmp = J_GOTO; c.target = U_REPORT;
        c.mem_we = 1'b1; c.wsel = WD_A; c.wv = WV_A;
      end
      U_BR:     begin c.jmp = J_GOTO; c.target = U_REPORT; c.pc_op = PC_BR; end
      U_JMP0:   begin c.rf_rd = 1'b1; c.rsel = RS_RS1; end
      U_JMP1:   begin c.jmp = J_GOTO; c.target = U_REPORT; c.pc_op = PC_JMP; end
      U_TRAP:   begin c.jmp = J_GOTO; c.target = U_REPORT; c.trap = 1'b1; end
      U_REPORT: begin c.jmp = J_GOTO; c.target = U_DISP; c.out_stb = 1'b1; end
      default:  begin c.jmp = J_GOTO; c.target = U_DISP; end
    endcase
    return c;
  endfunction

  function automatic logic [1:0] cc_of(input logic [15:0] v);
    logic [1:0] c;
    if (v[15]) begin
      c = CC_NEG;
    end else if (v == 16'd0) begin
      c = CC_ZERO;
    end else begin
      c = CC_POS;
    end
    return c;
  endfunction

  // Register file contents after reset.
  function automatic logic [15:0] rf_init(input logic [2:0] idx);
    logic [15:0] v;
    unique case (idx)
      3'd0:    v = 16'd30;
      3'd7:    v = 16'd5;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/lc3s_ram.sv
module lc3s_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/lc3s_mod.sv
module lc3s_mod #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [15:0]   value,
  output logic          done,
  output logic [AW-1:0] result
);

  // A power-of-two depth is a plain mask. Any other depth uses a reciprocal
  // multiply: after go the value is registered, then the quotient, then the
  // remainder, and done stays low until the remainder is registered.
  // The scaled reciprocal ceil(2^(16+AW) / DEPTH) gives the exact quotient
  // for every 16-bit value.
  localparam bit          POW2    = (DEPTH & (DEPTH - 1)) == 0;
  localparam logic [15:0] MASK16  = 16'(DEPTH - 1);
  localparam int          SH      = 16 + AW;
  localparam logic [63:0] RECIP   = ((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
  localparam logic [17:0] RECIP18 = RECIP[17:0];
  localparam logic [15:0] DIV16   = 16'(DEPTH);

  logic [15:0] rem_r;
  logic [15:0] val_r;
  logic [15:0] quo_r;
  logic        phase_r;
  logic        busy_r;
  logic [33:0] prod;
  logic [33:0] prod_sh;
  logic [31:0] qd;

  assign prod    = {18'd0, val_r} * {16'd0, RECIP18};
  assign prod_sh = prod >> SH;
  assign qd      = {16'd0, quo_r} * {16'd0, DIV16};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (go) begin
      if (POW2) begin
        rem_r  <= value & MASK16;
        busy_r <= 1'b0;
      end else begin
        val_r   <= value;
        phase_r <= 1'b0;
        busy_r  <= 1'b1;
      end
    end else if (busy_r) begin
      if (!phase_r) begin
        quo_r   <= prod_sh[15:0];
        phase_r <= 1'b1;
      end else begin
        rem_r  <= val_r - qd[15:0];
        busy_r <= 1'b0;
      end
    end
  end

  assign done   = !busy_r;
  assign result = rem_r[AW-1:0];

endmodule

### rtl/lc3s_useq.sv
module lc3s_useq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lc3s_pkg::cond_t       cond,
  output lc3s_pkg::upc_t        upc,
  output lc3s_pkg::ctrl_t       cw
);

  lc3s_pkg::upc_t upc_r;
  lc3s_pkg::upc_t upc_nxt;
  lc3s_pkg::upc_t upc_inc;

  assign cw      = lc3s_pkg::ucode(upc_r);
  assign upc     = upc_r;
  assign upc_inc = upc_r + 5'd1;

  always_comb begin
    upc_nxt = upc_r;
    unique case (cw.jmp)
      lc3s_pkg::J_NEXT: upc_nxt = upc_inc;
      lc3s_pkg::J_GOTO: upc_nxt = cw.target;
      lc3s_pkg::J_WAIT: upc_nxt = cond.mod_done ? upc_inc : upc_r;
      lc3s_pkg::J_DISP_OP: begin
        if (cond.go) begin
          unique case (cond.op)
            lc3s_pkg::OP_LOAD:    upc_nxt = lc3s_pkg::U_LOAD0;
            lc3s_pkg::OP_RESTART: upc_nxt = lc3s_pkg::U_RST;
            lc3s_pkg::OP_EXEC:
              upc_nxt = cond.halted ? lc3s_pkg::U_REPORT : lc3s_pkg::U_EX0;
            default:              upc_nxt = lc3s_pkg::U_REPORT;
          endcase
        end
      end
      lc3s_pkg::J_DISP_OPC: begin
        unique case (cond.opcode)
          lc3s_pkg::OPC_ADD,
          lc3s_pkg::OPC_AND:  upc_nxt = lc3s_pkg::U_ALU0;
          lc3s_pkg::OPC_NOT:  upc_nxt = lc3s_pkg::U_NOT0;
          lc3s_pkg::OPC_LD:   upc_nxt = lc3s_pkg::U_LD0;
          lc3s_pkg::OPC_ST:   upc_nxt = lc3s_pkg::U_ST0;
          lc3s_pkg::OPC_BR:   upc_nxt = lc3s_pkg::U_BR;
          lc3s_pkg::OPC_JMP:  upc_nxt = lc3s_pkg::U_JMP0;
          lc3s_pkg::OPC_TRAP: upc_nxt = lc3s_pkg::U_TRAP;
          default:            upc_nxt = lc3s_pkg::U_REPORT;
        endcase
      end
      default: upc_nxt = lc3s_pkg::U_DISP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= lc3s_pkg::U_DISP;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

### rtl/lc3_subset_cpu_core_unit.sv
// Small LC-3 subset processor. A request (start high while busy is low)
// loads one memory word, restarts the program, or executes one instruction;
// every request produces exactly one result, shown for a single cycle with
// out_valid, and the receiver cannot hold it off. After reset the block
// stays busy while it clears the word memory and sets up the register
// file. The time from a request to its result strobe is set by the
// micro-program steps through the single-port register file and word
// memory; a step while halted reports in the very next cycle. The next
// request is taken in the cycle after the strobe. When MEM_DEPTH is not
// a power of two, each memory address goes through a reciprocal-multiply
// modulo unit that registers a quotient and then a remainder (one address
// for a load, one for every executed instruction, two for LD and ST).
module lc3_subset_cpu_core_unit #(
  parameter int MEM_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [4:0]  in_load_address,
  input  logic [15:0] in_load_data,
  output logic        out_valid,
  output logic [15:0] out_program_counter,
  output logic [15:0] out_instruction_word,
  output logic [1:0]  out_condition_code,
  output logic        out_halted,
  output logic [15:0] out_written_value
);

  localparam int AW = $clog2(MEM_DEPTH);

  // Architectural state.
  logic [15:0] pc_r;
  logic [15:0] ir_r;
  logic [1:0]  cc_r;
  logic        halt_r;

  // Datapath work registers.
  logic [15:0] a_r;
  logic [15:0] wv_r;
  logic [4:0]  ld_addr_r;
  logic [15:0] ld_data_r;

  // Clearing sweep after reset.
  logic          clr_active_r;
  logic [AW-1:0] clr_idx_r;

  lc3s_pkg::upc_t  upc;
  lc3s_pkg::ctrl_t cw;
  lc3s_pkg::cond_t cond;

  logic go;
  logic mod_done;
  logic [AW-1:0] mod_result;
  logic [15:0]   mod_value;

  logic [15:0] mem_rdata;
  logic [15:0] rf_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          rf_we;
  logic [2:0]    rf_waddr;
  logic [15:0]   rf_wdata;
  logic [2:0]    rf_raddr;

  logic [15:0] off9;
  logic [15:0] imm5;
  logic [15:0] alu_b;
  logic [15:0] alu_out;
  logic [15:0] res;
  logic        br_take;

  assign busy = clr_active_r || (upc != lc3s_pkg::U_DISP);
  assign go   = start && !busy;

  assign cond.go       = go;
  assign cond.op       = in_operation;
  assign cond.halted   = halt_r;
  assign cond.opcode   = mem_rdata[15:12];  // the word being fetched
  assign cond.mod_done = mod_done;

  lc3s_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .upc   (upc),
    .cw    (cw)
  );

  // Immediate fields of the current instruction.
  assign off9 = {{7{ir_r[8]}}, ir_r[8:0]};
  assign imm5 = {{11{ir_r[4]}}, ir_r[4:0]};

  // Memory address generation: everything is reduced modulo the depth.
  always_comb begin
    unique case (cw.msel)
      lc3s_pkg::MS_PC:   mod_value = pc_r;
      lc3s_pkg::MS_OFF:  mod_value = pc_r + off9;
      lc3s_pkg::MS_LOAD: mod_value = {11'd0, ld_addr_r};
      default:           mod_value = pc_r;
    endcase
  end

  lc3s_mod #(.DEPTH(MEM_DEPTH)) u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (cw.mod_go),
    .value  (mod_value),
    .done   (mod_done),
    .result (mod_result)
  );

  // Word memory: the sweep owns the write port until it finishes.
  assign mem_we    = clr_active_r || cw.mem_we;
  assign mem_waddr = clr_active_r ? clr_idx_r : mod_result;
  assign mem_wdata = clr_active_r ? 16'd0 :
                     (cw.wsel == lc3s_pkg::WD_A) ? a_r : ld_data_r;

  lc3s_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .rd    (cw.mem_rd),
    .raddr (mod_result),
    .rdata (mem_rdata)
  );

  // Register file read address.
  always_comb begin
    unique case (cw.rsel)
      lc3s_pkg::RS_RS1: rf_raddr = ir_r[8:6];
      lc3s_pkg::RS_RS2: rf_raddr = ir_r[2:0];
      lc3s_pkg::RS_RD:  rf_raddr = ir_r[11:9];
      default:          rf_raddr = ir_r[8:6];
    endcase
  end

  // ALU and write-back selection.
  assign alu_b   = ir_r[5] ? imm5 : rf_rdata;
  assign alu_out = (ir_r[15:12] == lc3s_pkg::OPC_AND) ? (a_r & alu_b) : (a_r + alu_b);

  always_comb begin
    unique case (cw.rsrc)
      lc3s_pkg::RES_ALU: res = alu_out;
      lc3s_pkg::RES_NOT: res = ~rf_rdata;
      lc3s_pkg::RES_MEM: res = mem_rdata;
      default:           res = alu_out;
    endcase
  end

  // The first eight sweep steps also load the register file reset values.
  assign rf_we    = clr_active_r ? (clr_idx_r[AW-1:3] == '0) : cw.wb;
  assign rf_waddr = clr_active_r ? clr_idx_r[2:0] : ir_r[11:9];
  assign rf_wdata = clr_active_r ? lc3s_pkg::rf_init(clr_idx_r[2:0]) : res;

  lc3s_ram #(.WIDTH(16), .DEPTH(8)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .rd    (cw.rf_rd),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  // A branch is taken when the condition code matches one of its nzp bits.
  assign br_take = ((cc_r == lc3s_pkg::CC_NEG)  && ir_r[11]) ||
                   ((cc_r == lc3s_pkg::CC_ZERO) && ir_r[10]) ||
                   ((cc_r == lc3s_pkg::CC_POS)  && ir_r[9]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= 16'd0;
      ir_r         <= 16'd0;
      cc_r         <= lc3s_pkg::CC_ZERO;
      halt_r       <= 1'b0;
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else begin
      if (clr_active_r) begin
        if (clr_idx_r == AW'(MEM_DEPTH - 1)) begin
          clr_active_r <= 1'b0;
        end
        clr_idx_r <= clr_idx_r + 1'b1;
      end

      if (cw.ir_ld) begin
        ir_r <= mem_rdata;
        pc_r <= pc_r + 16'd1;
      end

      unique case (cw.pc_op)
        lc3s_pkg::PC_BR: begin
          if (br_take) begin
            pc_r <= pc_r + off9;
          end
        end
        lc3s_pkg::PC_JMP: pc_r <= rf_rdata;
        default: ;
      endcase

      if (cw.wb) begin
        cc_r <= lc3s_pkg::cc_of(res);
      end

      if (cw.trap && (ir_r[7:0] == lc3s_pkg::HALT_VECTOR)) begin
        halt_r <= 1'b1;
      end

      // Restart leaves registers, memory and the instruction word alone.
      if (cw.restart) begin
        pc_r   <= 16'd0;
        cc_r   <= lc3s_pkg::CC_ZERO;
        halt_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (go) begin
      ld_addr_r <= in_load_address;
      ld_data_r <= in_load_data;
    end
    if (cw.a_ld) begin
      a_r <= rf_rdata;
    end
    unique case (cw.wv)
      lc3s_pkg::WV_CLEAR: wv_r <= 16'd0;
      lc3s_pkg::WV_RES:   wv_r <= res;
      lc3s_pkg::WV_A:     wv_r <= a_r;
      lc3s_pkg::WV_LOAD:  wv_r <= ld_data_r;
      default: ;
    endcase
  end

  assign out_valid            = cw.out_stb;
  assign out_program_counter  = pc_r;
  assign out_instruction_word = ir_r;
  assign out_condition_code   = cc_r;
  assign out_halted           = halt_r;
  assign out_written_value    = wv_r;

`ifndef SYNTHESIS
  // An accepted request always puts the block to work.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy)
    else $error("request accepted but block did not go busy");

  // A result strobe lasts one cycle only.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // No result can appear during the memory clearing sweep.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (!out_valid && upc == lc3s_pkg::U_DISP))
    else $error("sequencer active during memory clearing");

  // A restart reports a cleared program counter and a cleared halt flag.
  a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
    (go && in_operation == lc3s_pkg::OP_RESTART) |->
      ##2 (out_valid && out_program_counter == 16'd0 && !out_halted))
    else $error("restart result wrong or late");
`endif

endmodule
